// ===== rtl/tlpte_pkg.sv =====
`default_nettype none

package tlpte_pkg;

	// Field geometry
	localparam int VA_W        = 26;
	localparam int PA_W        = 32;
	localparam int FLAGS_W     = 12;
	localparam int FRAME_W     = 20;
	localparam int WORD_W      = 32;
	localparam int TI_W        = 10;
	localparam int TI_LSB      = 12;
	localparam int DI_W        = VA_W - TI_LSB - TI_W;
	localparam int DI_LSB      = TI_LSB + TI_W;
	localparam int TABLE_SLOTS = 1 << TI_W;

	// Entry bits and masks
	localparam int          BIT_PRESENT  = 0;
	localparam int          BIT_LARGE    = 7;
	localparam logic [31:0] FRAME_MASK   = 32'hFFFF_F000;
	localparam logic [31:0] LARGE_MASK   = 32'hFFC0_0000;
	localparam logic [31:0] PRESENT_MASK = 32'h0000_0001;

	// Opcodes
	localparam logic [1:0] OP_MAP   = 2'd0;
	localparam logic [1:0] OP_UNMAP = 2'd1;
	localparam logic [1:0] OP_XLATE = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [VA_W-1:0]    virt_addr;
		logic [PA_W-1:0]    phys_addr;
		logic [FLAGS_W-1:0] page_flags;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [WORD_W-1:0] translated_addr;
	} rsp_t;

	// Write data selects
	typedef enum logic [1:0] {
		DW_ZERO  = 2'd0,
		DW_NEW   = 2'd1,
		DW_UNMAP = 2'd2
	} dir_wsel_t;

	typedef enum logic [1:0] {
		TW_CLEAR = 2'd0,
		TW_NEW   = 2'd1,
		TW_UNMAP = 2'd2
	} tab_wsel_t;

	// Controller to datapath
	typedef struct packed {
		logic      req_load;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      dir_we;
		dir_wsel_t dir_wsel;
		logic      tab_we;
		tab_wsel_t tab_wsel;
		logic      res_load;
		logic      out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       in_range;
		logic       dir_p;
		logic       dir_lg;
		logic       tab_p;
		logic       cnt_dir_last;
		logic       cnt_tab_last;
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/two_level_page_table_engine_unit.sv =====
// A request beat passes through the READ and EVAL states to RESP, where its result enters the output register.
// Only one request is in flight at a time: the next is taken after the RAM read, evaluate and output load.
// A map that creates a page table sweeps the whole table in S_CLEAR, one table entry cleared per cycle.
// Reset: arst_n asynchronous, active low; a directory clearing pass over every directory slot
// follows, with req_ready low. The pool base register is writable at any time.
`default_nettype none

module two_level_page_table_engine_unit #(
	parameter int DIR_SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tlpte_pkg::FRAME_W-1:0] cfg_wdata,
	input  wire logic                          req_valid,
	output logic                               req_ready,
	input  wire tlpte_pkg::req_t               req,
	output logic                               rsp_valid,
	input  wire logic                          rsp_ready,
	output tlpte_pkg::rsp_t                    rsp
);
	import tlpte_pkg::*;

	cmd_t    cmd;
	status_t st;

	tlpte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.st        (st),
		.cmd       (cmd)
	);

	tlpte_dp #(
		.DIR_SLOTS (DIR_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp),
		.cmd       (cmd),
		.st        (st)
	);

	// One request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	// Output register is never overwritten while a beat waits
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!rsp_valid || rsp_ready))
		else $error("result beat overwritten");

	// Directory and table are never written in the same cycle
	a_single_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.dir_we && cmd.tab_we))
		else $error("directory and table written together");

	// Table writes only for a directory slot that exists
	a_tab_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tab_we |-> st.in_range)
		else $error("table write for out-of-range slot");

endmodule

`default_nettype wire

// ===== rtl/tlpte_ram.sv =====
`default_nettype none

module tlpte_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/tlpte_ctrl.sv =====
`default_nettype none

module tlpte_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	input  wire tlpte_pkg::status_t st,
	output tlpte_pkg::cmd_t         cmd
);
	import tlpte_pkg::*;

	typedef enum logic [5:0] {
		S_INIT  = 6'b000001,
		S_IDLE  = 6'b000010,
		S_READ  = 6'b000100,
		S_EVAL  = 6'b001000,
		S_CLEAR = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   rsp_valid_q;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	// Next state and commands
	always_comb begin
		state_d      = state_q;
		cmd.req_load = 1'b0;
		cmd.cnt_clr  = 1'b0;
		cmd.cnt_inc  = 1'b0;
		cmd.dir_we   = 1'b0;
		cmd.dir_wsel = DW_ZERO;
		cmd.tab_we   = 1'b0;
		cmd.tab_wsel = TW_CLEAR;
		cmd.res_load = 1'b0;
		cmd.out_load = 1'b0;
		case (state_q)
			S_INIT: begin
				// directory clearing pass after reset
				cmd.dir_we   = 1'b1;
				cmd.dir_wsel = DW_ZERO;
				cmd.cnt_inc  = 1'b1;
				if (st.cnt_dir_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.req_load = 1'b1;
					state_d      = S_READ;
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL: begin
				cmd.res_load = 1'b1;
				state_d      = S_RESP;
				if (st.in_range) begin
					case (st.op)
						OP_MAP: begin
							if (!st.dir_p) begin
								// new table: set directory word, then sweep the table
								cmd.dir_we   = 1'b1;
								cmd.dir_wsel = DW_NEW;
								cmd.cnt_clr  = 1'b1;
								state_d      = S_CLEAR;
							end else if (!st.tab_p) begin
								cmd.tab_we   = 1'b1;
								cmd.tab_wsel = TW_NEW;
							end
						end
						OP_UNMAP: begin
							if (st.dir_p && st.dir_lg) begin
								cmd.dir_we   = 1'b1;
								cmd.dir_wsel = DW_UNMAP;
							end else if (st.dir_p && st.tab_p) begin
								cmd.tab_we   = 1'b1;
								cmd.tab_wsel = TW_UNMAP;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_CLEAR: begin
				// zero every entry, the requested one takes the new mapping
				cmd.tab_we   = 1'b1;
				cmd.tab_wsel = TW_CLEAR;
				cmd.cnt_inc  = 1'b1;
				if (st.cnt_tab_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tlpte_dp.sv =====
`default_nettype none

module tlpte_dp #(
	parameter int DIR_SLOTS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [tlpte_pkg::FRAME_W-1:0] cfg_wdata,
	input  wire tlpte_pkg::req_t               req,
	output tlpte_pkg::rsp_t                    rsp,
	input  wire tlpte_pkg::cmd_t               cmd,
	output tlpte_pkg::status_t                 st
);
	import tlpte_pkg::*;

	localparam int DIR_AW    = (DIR_SLOTS > 1) ? $clog2(DIR_SLOTS) : 1;
	localparam int TAB_DEPTH = DIR_SLOTS * TABLE_SLOTS;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int CNT_W     = (DIR_AW > TI_W) ? DIR_AW : TI_W;

	logic [FRAME_W-1:0] pool_q;
	req_t               req_q;
	logic [CNT_W-1:0]   cnt_q;
	rsp_t               res_q;
	rsp_t               rsp_q;

	logic [DI_W-1:0]   di;
	logic [TI_W-1:0]   ti;
	logic [31:0]       di_ext;
	logic [DIR_AW-1:0] dir_addr;
	logic [DIR_AW-1:0] dir_waddr;
	logic [TI_W-1:0]   tab_widx;
	logic [31:0]       tab_rfull;
	logic [31:0]       tab_wfull;
	logic [WORD_W-1:0] dw;
	logic [WORD_W-1:0] tw;
	logic [WORD_W-1:0] dir_wdata;
	logic [WORD_W-1:0] tab_wdata;
	logic [WORD_W-1:0] dir_new;
	logic [WORD_W-1:0] tab_new;
	logic [WORD_W-1:0] va_ext;
	logic [FRAME_W-1:0] frame;
	logic              in_range;
	logic              res_ok;
	logic [WORD_W-1:0] res_addr;

	// Pool base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q <= '0;
		end else if (cfg_we) begin
			pool_q <= cfg_wdata;
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.req_load) begin
			req_q <= req;
		end
	end

	// Sweep counter for directory init and table clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// Index decode
	assign di        = req_q.virt_addr[DI_LSB +: DI_W];
	assign ti        = req_q.virt_addr[TI_LSB +: TI_W];
	assign di_ext    = 32'(di);
	assign in_range  = di_ext < 32'(DIR_SLOTS);
	assign dir_addr  = di_ext[DIR_AW-1:0];
	assign dir_waddr = (cmd.dir_wsel == DW_ZERO) ? cnt_q[DIR_AW-1:0] : dir_addr;
	assign tab_widx  = (cmd.tab_wsel == TW_CLEAR) ? cnt_q[TI_W-1:0] : ti;
	assign tab_rfull = {di_ext[31-TI_W:0], ti};
	assign tab_wfull = {di_ext[31-TI_W:0], tab_widx};

	// New entry words
	assign frame   = pool_q + FRAME_W'(di);
	assign dir_new = ({frame, {TI_LSB{1'b0}}} | 32'(req_q.page_flags)) | PRESENT_MASK;
	assign tab_new = (req_q.phys_addr & FRAME_MASK) | 32'(req_q.page_flags) | PRESENT_MASK;

	always_comb begin
		case (cmd.dir_wsel)
			DW_NEW:   dir_wdata = dir_new;
			DW_UNMAP: dir_wdata = dw & ~PRESENT_MASK;
			default:  dir_wdata = '0;
		endcase
	end

	always_comb begin
		case (cmd.tab_wsel)
			TW_NEW:   tab_wdata = tab_new;
			TW_UNMAP: tab_wdata = tw & ~PRESENT_MASK;
			default:  tab_wdata = (cnt_q[TI_W-1:0] == ti) ? tab_new : '0;
		endcase
	end

	tlpte_ram #(
		.WIDTH (WORD_W),
		.DEPTH (DIR_SLOTS)
	) u_dir_ram (
		.clk   (clk),
		.we    (cmd.dir_we),
		.waddr (dir_waddr),
		.wdata (dir_wdata),
		.raddr (dir_addr),
		.rdata (dw)
	);

	tlpte_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TAB_DEPTH)
	) u_tab_ram (
		.clk   (clk),
		.we    (cmd.tab_we),
		.waddr (tab_wfull[TAB_AW-1:0]),
		.wdata (tab_wdata),
		.raddr (tab_rfull[TAB_AW-1:0]),
		.rdata (tw)
	);

	// Result of the walk
	assign va_ext = 32'(req_q.virt_addr);

	always_comb begin
		res_ok   = 1'b0;
		res_addr = '0;
		if (in_range) begin
			case (req_q.opcode)
				OP_MAP: begin
					res_ok = !dw[BIT_PRESENT] || !tw[BIT_PRESENT];
				end
				OP_UNMAP: begin
					res_ok = dw[BIT_PRESENT] && (dw[BIT_LARGE] || tw[BIT_PRESENT]);
				end
				OP_XLATE: begin
					res_ok = dw[BIT_PRESENT] && (dw[BIT_LARGE] || tw[BIT_PRESENT]);
					if (res_ok) begin
						if (dw[BIT_LARGE]) begin
							res_addr = (dw & LARGE_MASK) | (va_ext & ~LARGE_MASK);
						end else begin
							res_addr = (tw & FRAME_MASK) | (va_ext & ~FRAME_MASK);
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q.ok              <= res_ok;
			res_q.translated_addr <= res_addr;
		end
		if (cmd.out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp = rsp_q;

	// Status to controller
	assign st.op           = req_q.opcode;
	assign st.in_range     = in_range;
	assign st.dir_p        = dw[BIT_PRESENT];
	assign st.dir_lg       = dw[BIT_LARGE];
	assign st.tab_p        = tw[BIT_PRESENT];
	assign st.cnt_dir_last = (cnt_q == CNT_W'(DIR_SLOTS - 1));
	assign st.cnt_tab_last = (cnt_q[TI_W-1:0] == TI_W'(TABLE_SLOTS - 1));

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tlpte_pkg::*;

	localparam int DIR_SLOTS = 16;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 5000;

	// Shadow copy of the directory and tables; predicts one reply per request beat
	class mmu_shadow;
		logic [WORD_W-1:0] dir_words [DIR_SLOTS];
		logic [WORD_W-1:0] tab_words [DIR_SLOTS*TABLE_SLOTS];
		logic [FRAME_W-1:0] pool_frame;
		rsp_t replies_due [$];
		int faults, replies_seen, tables_made;
		int maps_ok, maps_refused, unmaps_ok, large_hits, small_hits, misses;

		function new();
			foreach (dir_words[i]) dir_words[i] = '0;
			foreach (tab_words[i]) tab_words[i] = '0;
			pool_frame = '0;
		endfunction

		function void apply_request(req_t r);
			logic [DI_W-1:0] di;
			logic [TI_W-1:0] ti;
			int unsigned slot;
			logic [FRAME_W-1:0] frame;
			logic [WORD_W-1:0] va32;
			logic [WORD_W-1:0] fl32;
			rsp_t due;
			di = r.virt_addr[DI_LSB +: DI_W];
			ti = r.virt_addr[TI_LSB +: TI_W];
			va32 = {{(WORD_W-VA_W){1'b0}}, r.virt_addr};
			fl32 = {{(WORD_W-FLAGS_W){1'b0}}, r.page_flags};
			due = '0;
			if (int'(di) < DIR_SLOTS) begin
				slot = int'(di) * TABLE_SLOTS + int'(ti);
				case (r.opcode)
					OP_MAP: begin
						// missing table: point the directory at its pool frame, wipe it
						if (!dir_words[di][BIT_PRESENT]) begin
							frame = pool_frame + FRAME_W'(di);
							dir_words[di] = {frame, 12'h000} | PRESENT_MASK | fl32;
							for (int i = 0; i < TABLE_SLOTS; i++)
								tab_words[int'(di) * TABLE_SLOTS + i] = '0;
							tables_made++;
						end
						if (!tab_words[slot][BIT_PRESENT]) begin
							tab_words[slot] = (r.phys_addr & FRAME_MASK) | PRESENT_MASK | fl32;
							due.ok = 1'b1;
							maps_ok++;
						end else begin
							maps_refused++;
						end
					end
					OP_UNMAP: begin
						if (dir_words[di][BIT_PRESENT]) begin
							if (dir_words[di][BIT_LARGE]) begin
								dir_words[di][BIT_PRESENT] = 1'b0;
								due.ok = 1'b1;
							end else if (tab_words[slot][BIT_PRESENT]) begin
								tab_words[slot][BIT_PRESENT] = 1'b0;
								due.ok = 1'b1;
							end
						end
						if (due.ok) unmaps_ok++;
					end
					OP_XLATE: begin
						if (dir_words[di][BIT_PRESENT]) begin
							if (dir_words[di][BIT_LARGE]) begin
								due.translated_addr = (dir_words[di] & LARGE_MASK) | (va32 & ~LARGE_MASK);
								due.ok = 1'b1;
								large_hits++;
							end else if (tab_words[slot][BIT_PRESENT]) begin
								due.translated_addr = (tab_words[slot] & FRAME_MASK) | (va32 & ~FRAME_MASK);
								due.ok = 1'b1;
								small_hits++;
							end
						end
						if (!due.ok) misses++;
					end
					default: ;
				endcase
			end
			replies_due.push_back(due);
		endfunction

		function void compare_reply(rsp_t got);
			rsp_t due;
			if (replies_due.size() == 0) begin
				$display("%0t: reply beat with none pending: ok=%0b addr=%h",
					$time, got.ok, got.translated_addr);
				faults++;
				return;
			end
			due = replies_due.pop_front();
			replies_seen++;
			if (got.ok !== due.ok) begin
				$display("%0t: ok mismatch: expected %0b actual %0b", $time, due.ok, got.ok);
				faults++;
			end
			if (got.translated_addr !== due.translated_addr) begin
				$display("%0t: translated_addr mismatch: expected %h actual %h",
					$time, due.translated_addr, got.translated_addr);
				faults++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [FRAME_W-1:0] cfg_wdata = '0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	mmu_shadow shadow = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	int pool_writes = 0;

	two_level_page_table_engine_unit #(
		.DIR_SLOTS(DIR_SLOTS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Reply monitor
	always @(posedge clk) begin
		if (rsp_valid === 1'b1 && rsp_ready)
			shadow.compare_reply(rsp);
	end

	// Cycles without any beat on either channel
	always @(posedge clk) begin
		if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("%0t: no beat for %0d cycles, %0d replies pending",
			$time, QUIET_LIMIT, shadow.replies_due.size());
		$display("tb failed");
		$finish;
	end

	function automatic logic [VA_W-1:0] va_of(int di, int ti, int off);
		return {DI_W'(di), TI_W'(ti), TI_LSB'(off)};
	endfunction

	// Few table slots per directory so that maps collide often
	function automatic logic [VA_W-1:0] pick_va();
		int ti;
		ti = ($urandom_range(0, 3) == 0) ? $urandom_range(0, TABLE_SLOTS-1) : $urandom_range(0, 7);
		return va_of($urandom_range(0, DIR_SLOTS-1), ti, $urandom_range(0, 4095));
	endfunction

	task automatic send_request(input logic [1:0] op, input logic [VA_W-1:0] va,
		input logic [PA_W-1:0] pa, input logic [FLAGS_W-1:0] fl);
		req_t r;
		r.opcode = op;
		r.virt_addr = va;
		r.phys_addr = pa;
		r.page_flags = fl;
		if ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (req_ready !== 1'b1);
		shadow.apply_request(r);
		if (op != OP_UNUSED) items_sent++;
	endtask

	task automatic drain_replies();
		req_valid <= 1'b0;
		@(posedge clk);
		while (shadow.replies_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_pool_frame(input logic [FRAME_W-1:0] v);
		drain_replies();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		shadow.pool_frame = v;
		pool_writes++;
		cfg_we <= 1'b0;
	endtask

	task automatic run_directed();
		// empty directory, unused opcode
		send_request(OP_XLATE, va_of(0, 0, 0), '0, '0);
		send_request(OP_UNMAP, va_of(0, 0, 0), '0, '0);
		send_request(OP_UNUSED, '1, '1, '1);
		// small page: create, refuse, translate
		send_request(OP_MAP, va_of(0, 0, 0), 32'hFFFF_FFFF, 12'h000);
		send_request(OP_MAP, va_of(0, 0, 0), 32'h1234_5000, 12'h000);
		send_request(OP_XLATE, va_of(0, 0, 12'hFFF), '0, '0);
		// large page in the top slot, then unmap and rebuild it small
		send_request(OP_MAP, '1, 32'h0000_0000, 12'hFFF);
		send_request(OP_XLATE, '1, '0, '0);
		send_request(OP_MAP, va_of(15, 5, 0), 32'hA5A5_A000, 12'h001);
		send_request(OP_UNMAP, va_of(15, 5, 0), '0, '0);
		send_request(OP_XLATE, '1, '0, '0);
		send_request(OP_UNMAP, '1, '0, '0);
		send_request(OP_MAP, va_of(15, 1023, 0), 32'h8000_0000, 12'h000);
		send_request(OP_XLATE, va_of(15, 1023, 12'h800), '0, '0);
		// small unmap and remap in an existing table
		send_request(OP_UNMAP, va_of(0, 0, 0), '0, '0);
		send_request(OP_XLATE, va_of(0, 0, 0), '0, '0);
		send_request(OP_UNMAP, va_of(0, 0, 0), '0, '0);
		send_request(OP_MAP, va_of(0, 0, 0), 32'h0000_0FFF, 12'h7FE);
		// pool at its top: directory frame wraps
		set_pool_frame(20'hFFFFF);
		send_request(OP_MAP, va_of(1, 2, 3), 32'h0000_0000, 12'h080);
		send_request(OP_XLATE, va_of(1, 0, 12'hABC), '0, '0);
	endtask

	task automatic run_traffic(input int n);
		int goal;
		logic [VA_W-1:0] va;
		logic [PA_W-1:0] pa;
		logic [FLAGS_W-1:0] fl;
		goal = items_sent + n;
		while (items_sent < goal) begin
			if ($urandom_range(0, 59) == 0) drain_replies();
			va = pick_va();
			pa = $urandom();
			fl = FLAGS_W'($urandom_range(0, 4095));
			if ($urandom_range(0, 3) != 0) begin
				// map, look it up, maybe tear it down, look again and map again
				if (!shadow.dir_words[va[DI_LSB +: DI_W]][BIT_PRESENT])
					fl[BIT_LARGE] = ($urandom_range(0, 3) != 0);
				send_request(OP_MAP, va, pa, fl);
				send_request(OP_XLATE, va, $urandom(), FLAGS_W'($urandom()));
				send_request(OP_XLATE, {va[VA_W-1:TI_LSB], TI_LSB'($urandom())},
					$urandom(), FLAGS_W'($urandom()));
				if ($urandom_range(0, 1) == 0)
					send_request(OP_UNMAP, va, $urandom(), FLAGS_W'($urandom()));
				if ($urandom_range(0, 1) == 0)
					send_request(OP_XLATE, va, $urandom(), FLAGS_W'($urandom()));
				if ($urandom_range(0, 2) == 0)
					send_request(OP_MAP, va, $urandom(), FLAGS_W'($urandom()));
			end else begin
				send_request(2'($urandom_range(0, 3)), va, pa, fl);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 25;
		recv_stall_pct = 62;
		run_directed();
		set_pool_frame(FRAME_W'($urandom()));
		run_traffic(630);

		send_idle_pct = 62;
		recv_stall_pct = 25;
		set_pool_frame(20'hFFC00);
		run_traffic(630);

		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_pool_frame(20'h00000);
		run_traffic(620);

		drain_replies();
		repeat (10) @(posedge clk);

		$display("%0d requests, %0d replies, %0d pool writes, %0d tables built",
			items_sent, shadow.replies_seen, pool_writes, shadow.tables_made);
		$display("maps %0d ok / %0d refused, unmaps %0d ok, hits %0d large / %0d small, misses %0d",
			shadow.maps_ok, shadow.maps_refused, shadow.unmaps_ok,
			shadow.large_hits, shadow.small_hits, shadow.misses);
		if (shadow.faults == 0 && shadow.replies_due.size() == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
